/* hdl/tmd_pkg.sv */
package tmd_pkg;

  // Field widths
  localparam int VAL_W     = 24;
  localparam int OUT_W     = 48;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'd1;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // One classified element pair
  typedef struct packed {
    logic [VAL_W-1:0] diff;
    logic             hit;
    logic             mode;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } fifo_stat_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] operand;
  } sqrt_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TERM_MUL,
    S_TERM_ADD,
    S_TERM_ROOT,
    S_FINISH,
    S_FINAL_MUL,
    S_FINAL_OUT,
    S_FINAL_ROOT
  } back_state_t;

endpackage

/* hdl/tmd_front.sv */
module tmd_front import tmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic [VAL_W-1:0]     own_value,
  input  logic [VAL_W-1:0]     other_value,
  input  logic                 last_element,
  output entry_t               entry
);

  logic [VAL_W-1:0] threshold;
  logic             mode;
  logic [VAL_W-1:0] diff;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      mode      <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_MODE:      mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the pair: absolute difference against the threshold
  always_comb begin
    diff       = (own_value > other_value) ? own_value - other_value
                                           : other_value - own_value;
    entry.diff = diff;
    entry.hit  = diff > threshold;
    entry.mode = mode;
    entry.last = last_element;
  end

endmodule

/* hdl/tmd_fifo.sv */
module tmd_fifo import tmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  entry_t     wr_entry,
  input  logic       pop,
  output entry_t     rd_entry,
  output fifo_stat_t stat
);

  entry_t           slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Store items
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wr_entry;
  end

  assign rd_entry   = slots[rptr];
  assign stat.count = count;
  assign stat.full  = (count == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

endmodule

/* hdl/tmd_isqrt.sv */
module tmd_isqrt import tmd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_SW = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  x;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [CNT_SW-1:0] cnt;
  logic              busy;
  logic              done;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              take;

  // One result bit per cycle, restoring method
  always_comb begin
    rem_sh = {rem, x[SUM_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    take   = rem_sh >= trial;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_SW'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= req.operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x <= {x[SUM_W-3:0], 2'b00};
      if (take) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.root = root;

endmodule

/* hdl/tmd_back.sv */
module tmd_back import tmd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  entry_t           head,
  input  fifo_stat_t       fstat,
  output logic             pop,
  output sqrt_req_t        sreq,
  input  sqrt_rsp_t        srsp,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] error_value
);

  back_state_t      state;
  back_state_t      state_next;
  entry_t           cur;
  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic [SUM_W-1:0] prod;
  logic [31:0]      mul_op;
  logic             emit;
  logic [OUT_W-1:0] emit_value;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and controls
  always_comb begin
    state_next       = state;
    pop              = 1'b0;
    sreq.start       = 1'b0;
    sreq.operand     = {{(SUM_W-VAL_W-16){1'b0}}, head.diff, 16'b0};
    running_sum_next = running_sum;
    emit             = 1'b0;
    emit_value       = prod[OUT_W+15:16];
    unique case (state)
      S_IDLE: begin
        if (!fstat.empty) begin
          pop = 1'b1;
          if (head.hit && head.mode) begin
            sreq.start = 1'b1;
            state_next = S_TERM_ROOT;
          end else if (head.hit) begin
            state_next = S_TERM_MUL;
          end else if (head.last) begin
            state_next = S_FINISH;
          end
        end
      end
      S_TERM_MUL: state_next = S_TERM_ADD;
      S_TERM_ADD: begin
        running_sum_next = sat_add(running_sum, prod);
        state_next       = cur.last ? S_FINISH : S_IDLE;
      end
      S_TERM_ROOT: begin
        if (srsp.done) begin
          running_sum_next = sat_add(running_sum, {{(SUM_W-ROOT_W){1'b0}}, srsp.root});
          state_next       = cur.last ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (!out_valid) begin
          if (cur.mode && running_sum[SUM_W-1:32] != '0) begin
            emit             = 1'b1;
            emit_value       = OUT_MAX;
            running_sum_next = '0;
            state_next       = S_IDLE;
          end else if (cur.mode) begin
            state_next = S_FINAL_MUL;
          end else begin
            sreq.start   = 1'b1;
            sreq.operand = running_sum;
            state_next   = S_FINAL_ROOT;
          end
        end
      end
      S_FINAL_MUL: state_next = S_FINAL_OUT;
      S_FINAL_OUT: begin
        emit             = 1'b1;
        running_sum_next = '0;
        state_next       = S_IDLE;
      end
      S_FINAL_ROOT: begin
        if (srsp.done) begin
          emit             = 1'b1;
          emit_value       = {{(OUT_W-ROOT_W){1'b0}}, srsp.root};
          running_sum_next = '0;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the item under work
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  // Shared multiplier: square of the difference, or of the summed roots
  assign mul_op = (state == S_FINAL_MUL) ? running_sum[31:0]
                                         : {{(32-VAL_W){1'b0}}, cur.diff};
  always_ff @(posedge clk) begin
    prod <= SUM_W'(mul_op * mul_op);
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (rst) running_sum <= '0;
    else     running_sum <= running_sum_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) error_value <= emit_value;
  end

endmodule

/* hdl/thresholded_matrix_distance.sv */
// Channel  | handshake           | payload
// ---------+---------------------+------------------------------------------
// in       | in_valid, in_ready  | own_value, other_value, last_element
// out      | out_valid,out_ready | error_value
// cfg      | cfg_wen             | cfg_index, cfg_data (no wait, no read-back)
//
// Items enter a four-deep queue; in_ready drops only while it is full.
// Back end: a counted pair in mode 0 is popped, multiplied and added; in
// mode 1 its root comes from the one-bit-per-cycle square-root unit.
// An uncounted pair is only popped. A last pair then squares the summed roots
// in mode 1 (32x32 multiplier) or roots the sum in mode 0 (square-root unit).
// Results wait in an output register as items queue; reset clears no payload.
module thresholded_matrix_distance import tmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VAL_W-1:0]     own_value,
  input  logic [VAL_W-1:0]     other_value,
  input  logic                 last_element,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     error_value
);

  entry_t     wr_entry;
  entry_t     head;
  fifo_stat_t fstat;
  logic       push;
  logic       pop;
  sqrt_req_t  sreq;
  sqrt_rsp_t  srsp;

  assign in_ready = !fstat.full;
  assign push     = in_valid && in_ready;

  tmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .own_value    (own_value),
    .other_value  (other_value),
    .last_element (last_element),
    .entry        (wr_entry)
  );

  tmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .stat     (fstat)
  );

  tmd_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  tmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .fstat       (fstat),
    .pop         (pop),
    .sreq        (sreq),
    .srsp        (srsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .error_value (error_value)
  );

  // Queue level never passes its depth
  a_fifo_level: assert property (@(posedge clk) disable iff (rst)
    fstat.count <= CNT_W'(FIFO_DEPTH))
    else $error("queue level beyond depth");

  // A push without a pop raises the level by one
  a_fifo_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fstat.count == $past(fstat.count) + 1'b1)
    else $error("queue level did not follow push");

  // Never pop an empty queue
  a_fifo_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fstat.empty)
    else $error("pop from empty queue");

  // Root unit is never restarted while it runs, and always takes a start
  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    sreq.start |-> !srsp.busy)
    else $error("root unit restarted while busy");

  a_sqrt_start: assert property (@(posedge clk) disable iff (rst)
    sreq.start |=> srsp.busy)
    else $error("root unit ignored start");

endmodule
